FILE: rtl/iss_pkg.sv
// Shared types and constants for the image header size sniffer.
package iss_pkg;

	localparam int POS_BITS = 24;

	localparam logic FMT_PNG  = 1'b0;
	localparam logic FMT_JPEG = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       end_of_file;
	} iss_step_t;

	typedef struct packed {
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic        status;
	} iss_result_t;

endpackage

FILE: rtl/iss_parser.sv
// Header parse state and per-byte next-state logic for PNG and JPEG files.
module iss_parser import iss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mode,
	input  logic        restart,
	input  iss_step_t   step,
	output iss_result_t result
);

	localparam int TGT_BITS = POS_BITS + 18;

	localparam logic [2:0] PH_HEAD  = 3'd0;
	localparam logic [2:0] PH_SEEK  = 3'd1;
	localparam logic [2:0] PH_MTYPE = 3'd2;
	localparam logic [2:0] PH_LENHI = 3'd3;
	localparam logic [2:0] PH_LENLO = 3'd4;
	localparam logic [2:0] PH_SOF   = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;
	localparam logic [2:0] PH_FAIL  = 3'd7;

	localparam logic [7:0] B_FF = 8'hFF;
	localparam logic [7:0] B_D8 = 8'hD8;
	localparam logic [7:0] B_E0 = 8'hE0;
	localparam logic [7:0] B_C0 = 8'hC0;
	localparam logic [7:0] B_J  = 8'h4A;
	localparam logic [7:0] B_F  = 8'h46;
	localparam logic [7:0] B_I  = 8'h49;
	localparam logic [7:0] B_00 = 8'h00;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [POS_BITS-1:0] pos_q, nmp_q, pos_n, nmp_n, off;
	logic [15:0]         len_q, len_n;
	logic [2:0]          phase_q, phase_n, ph_eff;
	logic [31:0]         width_q, height_q, width_n, height_n;
	logic                failed_q, failed_n;
	logic                sig_ok, adv_req, ok;
	logic [TGT_BITS-1:0] adv_base, target, pos_ext, nmp_ext;
	logic [7:0]          b;

	assign b       = step.data_byte;
	assign pos_ext = TGT_BITS'(pos_q);
	assign nmp_ext = TGT_BITS'(nmp_q);
	assign off     = pos_q - nmp_q;

	// JFIF signature bytes at fixed offsets
	always_comb begin
		unique case (pos_q)
			POS_BITS'(0):  sig_ok = (b == B_FF);
			POS_BITS'(1):  sig_ok = (b == B_D8);
			POS_BITS'(2):  sig_ok = (b == B_FF);
			POS_BITS'(3):  sig_ok = (b == B_E0);
			POS_BITS'(6):  sig_ok = (b == B_J);
			POS_BITS'(7):  sig_ok = (b == B_F);
			POS_BITS'(8):  sig_ok = (b == B_I);
			POS_BITS'(9):  sig_ok = (b == B_F);
			POS_BITS'(10): sig_ok = (b == B_00);
			default:       sig_ok = 1'b1;
		endcase
	end

	always_comb begin
		pos_n    = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
		nmp_n    = nmp_q;
		len_n    = len_q;
		phase_n  = phase_q;
		width_n  = width_q;
		height_n = height_q;
		failed_n = failed_q;
		ph_eff   = phase_q;
		adv_req  = 1'b0;
		adv_base = '0;
		target   = '0;
		if (mode == FMT_PNG) begin
			if (pos_q >= POS_BITS'(16) && pos_q <= POS_BITS'(19)) begin
				width_n = {width_q[23:0], b};
			end else if (pos_q >= POS_BITS'(20) && pos_q <= POS_BITS'(23)) begin
				height_n = {height_q[23:0], b};
			end
			if (pos_q == POS_BITS'(23)) begin
				phase_n = PH_DONE;
			end
		end else begin
			if (!sig_ok) begin
				failed_n = 1'b1;
				phase_n  = PH_FAIL;
				ph_eff   = PH_FAIL;
			end
			unique case (ph_eff)
				PH_HEAD: begin
					if (pos_q == POS_BITS'(4)) begin
						len_n = {b, 8'h00};
					end else if (pos_q == POS_BITS'(5)) begin
						len_n    = len_q | {8'h00, b};
						adv_req  = 1'b1;
						adv_base = TGT_BITS'(4);
					end
				end
				PH_SEEK: begin
					if (pos_q == nmp_q) begin
						if (b == B_FF) begin
							phase_n = PH_MTYPE;
						end else begin
							// not a marker: skip the previous length again
							adv_req  = 1'b1;
							adv_base = nmp_ext;
						end
					end
				end
				PH_MTYPE: begin
					phase_n = (b == B_C0) ? PH_SOF : PH_LENHI;
				end
				PH_LENHI: begin
					len_n   = {b, 8'h00};
					phase_n = PH_LENLO;
				end
				PH_LENLO: begin
					len_n    = len_q | {8'h00, b};
					adv_req  = 1'b1;
					adv_base = nmp_ext + TGT_BITS'(2);
				end
				PH_SOF: begin
					if (off == POS_BITS'(5) || off == POS_BITS'(6)) begin
						height_n = {16'h0000, height_q[7:0], b};
					end else if (off == POS_BITS'(7) || off == POS_BITS'(8)) begin
						width_n = {16'h0000, width_q[7:0], b};
					end
					if (off >= POS_BITS'(8)) begin
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
			if (adv_req) begin
				if (len_n == 16'h0000) begin
					failed_n = 1'b1;
					phase_n  = PH_FAIL;
				end else begin
					target = adv_base + TGT_BITS'(len_n);
					if (target <= pos_ext) begin
						target = pos_ext + TGT_BITS'(1);
					end
					if (target > TGT_BITS'(POS_MAX)) begin
						failed_n = 1'b1;
						phase_n  = PH_FAIL;
					end else begin
						nmp_n   = target[POS_BITS-1:0];
						phase_n = PH_SEEK;
					end
				end
			end
			// search ran into the saturated end of the position range
			if (pos_q == POS_MAX && phase_n != PH_DONE) begin
				failed_n = 1'b1;
				phase_n  = PH_FAIL;
			end
		end
	end

	always_comb begin
		if (mode == FMT_PNG) begin
			ok = (phase_n == PH_DONE);
		end else begin
			ok = (phase_n == PH_DONE) && !failed_n && !(width_n == '0 && height_n == '0);
		end
		result.image_width  = ok ? width_n : '0;
		result.image_height = ok ? height_n : '0;
		result.status       = !ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			nmp_q    <= '0;
			len_q    <= '0;
			phase_q  <= PH_HEAD;
			width_q  <= '0;
			height_q <= '0;
			failed_q <= 1'b0;
		end else if (restart || (step.valid && step.end_of_file)) begin
			pos_q    <= '0;
			nmp_q    <= '0;
			len_q    <= '0;
			phase_q  <= PH_HEAD;
			width_q  <= '0;
			height_q <= '0;
			failed_q <= 1'b0;
		end else if (step.valid) begin
			pos_q    <= pos_n;
			nmp_q    <= nmp_n;
			len_q    <= len_n;
			phase_q  <= phase_n;
			width_q  <= width_n;
			height_q <= height_n;
			failed_q <= failed_n;
		end
	end

endmodule

FILE: rtl/image_header_size_sniffer_top.sv
// Path: an accepted last byte of a file passes the input register, then the result register, to the master side.
// Throughput: one byte per cycle; the input register drains into the parse state each cycle.
// Only a last byte waits, and only while the result register holds an untaken result.
// Reset (arst_n low, asynchronous): empty input and result registers, PNG format,
// parse state at offset 0 in the signature check.
module image_header_size_sniffer_top import iss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// format register write: cfg_data bit 0 = format_mode (0 PNG, 1 JPEG)
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_file
	// result out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] image_width, [63:32] image_height
	output logic        m_axis_tuser    // status: 0 found, 1 invalid
);

	logic        mode_q;
	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        in_last_s1;
	logic        res_valid_s2;
	iss_result_t res_s2;
	iss_result_t result;
	iss_step_t   step;
	logic        res_free, s1_adv, in_acc, cfg_acc;

	// Writes must only arrive while idle; the block itself does not enforce this. The register is always ready.
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FMT_PNG;
		end else if (cfg_acc) begin
			mode_q <= cfg_data;
		end
	end

	// A byte that is not the last one produces no result and always advances;
	// the last byte advances only when the result register can take its result.
	assign res_free      = !res_valid_s2 || m_axis_tready;
	assign s1_adv        = in_valid_s1 && (!in_last_s1 || res_free);
	assign s_axis_tready = !in_valid_s1 || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Input register: hold the item until the parse stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_byte_s1 <= s_axis_tdata;
			in_last_s1 <= s_axis_tlast;
		end
	end

	assign step.valid       = s1_adv;
	assign step.data_byte   = in_byte_s1;
	assign step.end_of_file = in_last_s1;

	// Parse state advances one byte per step and computes the result of a last byte.
	iss_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.restart (cfg_acc),
		.step    (step),
		.result  (result)
	);

	// Result register: load on the last byte of a file, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_adv && in_last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_last_s1) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = {res_s2.image_height, res_s2.image_width};
	assign m_axis_tuser  = res_s2.status;

	// An invalid result carries zero dimensions.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero dimensions");

	// The input register only stalls on a last byte behind an untaken result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !s1_adv |-> in_last_s1 && res_valid_s2 && !m_axis_tready)
		else $error("input register stalled without cause");

	// Input side back-pressure comes only from a held last byte.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> in_valid_s1 && in_last_s1)
		else $error("input not ready without a pending last byte");

	// A last byte that advances shows its result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && in_last_s1 |=> m_axis_tvalid)
		else $error("result missing after last byte");

endmodule
